// ===== rtl/core/sdi_pkg.sv =====
// Types, codes and command frame table for the SD card SPI init sequencer.
package sdi_pkg;

  typedef struct packed {
    logic       start_req;
    logic [7:0] rx_byte;
  } sdi_in_t;

  typedef struct packed {
    logic       exchange;
    logic [7:0] tx_byte;
    logic       cs_level;
    logic       cs_pulse;
    logic       done_res;
    logic [3:0] card_type;
  } sdi_out_t;

  typedef enum logic [4:0] {
    P_IDLE    = 5'd0,
    P_DUMMY   = 5'd1,
    P_DISCARD = 5'd2,
    P_READY   = 5'd3,
    P_FRAME   = 5'd4,
    P_RESP    = 5'd5,
    P_TRAILER = 5'd6,
    P_RELEASE = 5'd7,
    K_CMD0    = 5'd8,
    K_CMD8    = 5'd9,
    K_R7      = 5'd10,
    K_HCS     = 5'd11,
    K_CMD58   = 5'd12,
    K_OCR     = 5'd13,
    K_PROBE   = 5'd14,
    K_V1      = 5'd15,
    K_MMC     = 5'd16,
    K_CMD16   = 5'd17
  } phase_t;

  typedef enum logic [3:0] {
    SEL_CMD0        = 4'd0,
    SEL_CMD8        = 4'd1,
    SEL_PRE_HCS     = 4'd2,
    SEL_ACMD41_HCS  = 4'd3,
    SEL_PRE_ZERO    = 4'd4,
    SEL_ACMD41_ZERO = 4'd5,
    SEL_CMD1        = 4'd6,
    SEL_CMD16       = 4'd7,
    SEL_CMD58       = 4'd8
  } cmd_sel_t;

  // follow-up action chosen while handling a response
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CMD,
    ACT_TRAILER,
    ACT_FINISH,
    ACT_LOOP,
    ACT_RETRY
  } act_t;

  localparam logic [1:0] REG_INIT_RETRY = 2'd0;
  localparam logic [1:0] REG_READY_WAIT = 2'd1;
  localparam logic [1:0] REG_DUMMY_CNT  = 2'd2;
  localparam logic [1:0] REG_RESP_POLL  = 2'd3;

  localparam logic [15:0] INIT_RETRY_RST = 16'd25000;
  localparam logic [15:0] READY_WAIT_RST = 16'd2500;
  localparam logic [7:0]  DUMMY_CNT_RST  = 8'd50;
  localparam logic [3:0]  RESP_POLL_RST  = 4'd10;

  localparam logic [7:0] BYTE_IDLE = 8'hFF;
  localparam logic [7:0] R7_VOLT   = 8'h01;
  localparam logic [7:0] R7_CHECK  = 8'hAA;
  localparam logic [2:0] FRAME_LEN = 3'd6;

  localparam logic [3:0] TYPE_NONE  = 4'h0;
  localparam logic [3:0] TYPE_MMC   = 4'h1;
  localparam logic [3:0] TYPE_SDV1  = 4'h2;
  localparam logic [3:0] TYPE_SDV2  = 4'h4;
  localparam logic [3:0] TYPE_SDV2B = 4'hC;

  localparam sdi_out_t RES_IDLE = '{exchange: 1'b0, tx_byte: 8'h00, cs_level: 1'b1,
                                    cs_pulse: 1'b0, done_res: 1'b0, card_type: 4'h0};

  function automatic sdi_out_t mk_emit(input logic [7:0] tx, input logic cs,
                                       input logic pulse);
    sdi_out_t r;
    r           = RES_IDLE;
    r.exchange  = 1'b1;
    r.tx_byte   = tx;
    r.cs_level  = cs;
    r.cs_pulse  = pulse;
    return r;
  endfunction

  // six-byte command frames; out-of-range selects fall back to CMD0
  function automatic logic [7:0] frame_byte(input cmd_sel_t sel, input logic [2:0] idx);
    logic [47:0] f;
    logic [7:0]  b;
    unique case (sel)
      SEL_CMD8:        f = 48'h48_00_00_01_AA_87;
      SEL_PRE_HCS:     f = 48'h77_00_00_00_00_01;
      SEL_ACMD41_HCS:  f = 48'h69_40_00_00_00_01;
      SEL_PRE_ZERO:    f = 48'h77_00_00_00_00_01;
      SEL_ACMD41_ZERO: f = 48'h69_00_00_00_00_01;
      SEL_CMD1:        f = 48'h41_00_00_00_00_01;
      SEL_CMD16:       f = 48'h50_00_00_02_00_01;
      SEL_CMD58:       f = 48'h7A_00_00_00_00_01;
      default:         f = 48'h40_00_00_00_00_95;
    endcase
    unique case (idx)
      3'd0:    b = f[47:40];
      3'd1:    b = f[39:32];
      3'd2:    b = f[31:24];
      3'd3:    b = f[23:16];
      3'd4:    b = f[15:8];
      default: b = f[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/sd_card_spi_init_sequencer_top.sv =====
// SD card SPI-mode init sequencer: config registers, step logic and output skid.
// Results go to the result register, or to the skid entry on a stall. Throughput: one
// input beat per cycle while in_stall is low; the step logic is one pass from the state
// registers to the result register, and a two-entry output buffer absorbs stalls.
// Reset (rst_n low, synchronous): sequencer idle, counters and flags cleared,
// config registers back to 25000 / 2500 / 50 / 10, output buffer empty.
module sd_card_spi_init_sequencer_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sdi_pkg::sdi_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sdi_pkg::sdi_out_t out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import sdi_pkg::*;

  logic [15:0] init_retry_r, ready_wait_r;
  logic [7:0]  dummy_cnt_r;
  logic [3:0]  resp_poll_r;

  phase_t      phase_r, phase_nxt;
  phase_t      ret_phase_r, ret_phase_nxt;
  logic [15:0] retry_cnt_r, retry_cnt_nxt;
  logic [15:0] wait_cnt_r, wait_cnt_nxt;
  logic [2:0]  frame_idx_r, frame_idx_nxt;
  cmd_sel_t    cmd_sel_r, cmd_sel_nxt;
  logic [7:0]  last_resp_r, last_resp_nxt;
  logic [1:0]  trl_idx_r, trl_idx_nxt;
  logic        trl_ok_r, trl_ok_nxt;
  logic [3:0]  det_type_r, det_type_nxt;

  sdi_out_t    res_nxt;
  logic        out_valid_r, skid_valid_r;
  sdi_out_t    out_data_r, skid_data_r;
  logic        in_acc, out_take, cfg_wr;

  // ---------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_retry_r <= INIT_RETRY_RST;
      ready_wait_r <= READY_WAIT_RST;
      dummy_cnt_r  <= DUMMY_CNT_RST;
      resp_poll_r  <= RESP_POLL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_INIT_RETRY: init_retry_r <= pwdata[15:0];
        REG_READY_WAIT: ready_wait_r <= pwdata[15:0];
        REG_DUMMY_CNT:  dummy_cnt_r  <= pwdata[7:0];
        REG_RESP_POLL:  resp_poll_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INIT_RETRY: prdata = {16'h0, init_retry_r};
      REG_READY_WAIT: prdata = {16'h0, ready_wait_r};
      REG_DUMMY_CNT:  prdata = {24'h0, dummy_cnt_r};
      REG_RESP_POLL:  prdata = {28'h0, resp_poll_r};
      default:        prdata = 32'h0;
    endcase
  end

  // ---------------- step logic
  always_comb begin
    logic [7:0]  resp;
    logic        tok;
    logic        do_hand;
    logic        do_disp;
    act_t        act;
    cmd_sel_t    a_sel;
    phase_t      a_ret;
    logic [3:0]  a_type;
    logic [15:0] rv;

    phase_nxt     = phase_r;
    ret_phase_nxt = ret_phase_r;
    retry_cnt_nxt = retry_cnt_r;
    wait_cnt_nxt  = wait_cnt_r;
    frame_idx_nxt = frame_idx_r;
    cmd_sel_nxt   = cmd_sel_r;
    last_resp_nxt = last_resp_r;
    trl_idx_nxt   = trl_idx_r;
    trl_ok_nxt    = trl_ok_r;
    det_type_nxt  = det_type_r;
    res_nxt       = RES_IDLE;

    resp    = 8'h00;
    tok     = trl_ok_r;
    do_hand = 1'b0;
    do_disp = 1'b0;
    act     = ACT_NONE;
    a_sel   = SEL_CMD0;
    a_ret   = P_IDLE;
    a_type  = TYPE_NONE;
    rv      = retry_cnt_r;

    if (in_data.start_req) begin
      det_type_nxt = TYPE_NONE;
      wait_cnt_nxt = (dummy_cnt_r != 8'd0) ? {8'h00, dummy_cnt_r} : 16'd1;
      phase_nxt    = P_DUMMY;
      res_nxt      = mk_emit(BYTE_IDLE, 1'b1, 1'b0);
    end else begin
      unique case (phase_r)
        P_DUMMY: begin
          wait_cnt_nxt = wait_cnt_r - 16'd1;
          if (wait_cnt_nxt != 16'd0) begin
            res_nxt = mk_emit(BYTE_IDLE, 1'b1, 1'b0);
          end else begin
            act   = ACT_CMD;
            a_sel = SEL_CMD0;
            a_ret = K_CMD0;
          end
        end
        P_DISCARD: begin
          wait_cnt_nxt = (ready_wait_r != 16'd0) ? ready_wait_r : 16'd1;
          phase_nxt    = P_READY;
          res_nxt      = mk_emit(BYTE_IDLE, 1'b0, 1'b0);
        end
        P_READY: begin
          if (in_data.rx_byte == BYTE_IDLE) begin
            frame_idx_nxt = 3'd0;
            phase_nxt     = P_FRAME;
            res_nxt       = mk_emit(frame_byte(cmd_sel_r, 3'd0), 1'b0, 1'b0);
          end else begin
            wait_cnt_nxt = wait_cnt_r - 16'd1;
            if (wait_cnt_nxt == 16'd0) begin
              // card never went ready: treat as an 0xFF response
              do_hand = 1'b1;
              resp    = BYTE_IDLE;
            end else begin
              res_nxt = mk_emit(BYTE_IDLE, 1'b0, 1'b0);
            end
          end
        end
        P_FRAME: begin
          frame_idx_nxt = frame_idx_r + 3'd1;
          if (frame_idx_nxt < FRAME_LEN) begin
            res_nxt = mk_emit(frame_byte(cmd_sel_r, frame_idx_nxt), 1'b0, 1'b0);
          end else begin
            wait_cnt_nxt = (resp_poll_r != 4'd0) ? {12'h000, resp_poll_r} : 16'd1;
            phase_nxt    = P_RESP;
            res_nxt      = mk_emit(BYTE_IDLE, 1'b0, 1'b0);
          end
        end
        P_RESP: begin
          wait_cnt_nxt = wait_cnt_r - 16'd1;
          if (in_data.rx_byte[7] && wait_cnt_nxt != 16'd0) begin
            res_nxt = mk_emit(BYTE_IDLE, 1'b0, 1'b0);
          end else begin
            do_hand = 1'b1;
            resp    = in_data.rx_byte;
          end
        end
        P_TRAILER: begin
          if (ret_phase_r == K_OCR) begin
            if (trl_idx_r == 2'd0) tok = in_data.rx_byte[6];  // CCS bit
          end else begin
            if (trl_idx_r == 2'd2) tok = (in_data.rx_byte == R7_VOLT);
            else if (trl_idx_r == 2'd3) tok = trl_ok_r && (in_data.rx_byte == R7_CHECK);
          end
          trl_ok_nxt = tok;
          if (trl_idx_r == 2'd3) begin
            do_disp = 1'b1;
            resp    = last_resp_r;
          end else begin
            trl_idx_nxt = trl_idx_r + 2'd1;
            res_nxt     = mk_emit(BYTE_IDLE, 1'b0, 1'b0);
          end
        end
        P_RELEASE: begin
          phase_nxt         = P_IDLE;
          res_nxt.done_res  = 1'b1;
          res_nxt.card_type = det_type_r;
        end
        default: phase_nxt = P_IDLE;
      endcase
    end

    // R1 handling; CMD55 with a good response moves on to its ACMD
    if (do_hand) begin
      last_resp_nxt = resp;
      if ((cmd_sel_r == SEL_PRE_HCS || cmd_sel_r == SEL_PRE_ZERO) && resp <= 8'd1) begin
        act   = ACT_CMD;
        a_sel = cmd_sel_t'(cmd_sel_r + 4'd1);
        a_ret = ret_phase_r;
      end else begin
        do_disp = 1'b1;
      end
    end

    if (do_disp) begin
      unique case (ret_phase_r)
        K_CMD0: begin
          if (resp == 8'd1) begin
            act = ACT_CMD; a_sel = SEL_CMD8; a_ret = K_CMD8;
          end else act = ACT_FINISH;
        end
        K_CMD8: begin
          if (resp == 8'd1) begin
            act = ACT_TRAILER; a_ret = K_R7;
          end else begin
            act = ACT_CMD; a_sel = SEL_PRE_ZERO; a_ret = K_PROBE;
          end
        end
        K_R7: begin
          if (tok) begin
            act = ACT_LOOP; a_sel = SEL_PRE_HCS; a_ret = K_HCS;
          end else act = ACT_FINISH;
        end
        K_HCS: begin
          if (resp == 8'd0) begin
            act = ACT_CMD; a_sel = SEL_CMD58; a_ret = K_CMD58;
          end else begin
            act = ACT_RETRY; a_sel = SEL_PRE_HCS; a_ret = K_HCS;
          end
        end
        K_CMD58: begin
          if (resp == 8'd0) begin
            act = ACT_TRAILER; a_ret = K_OCR;
          end else act = ACT_FINISH;
        end
        K_OCR: begin
          act    = ACT_FINISH;
          a_type = tok ? TYPE_SDV2B : TYPE_SDV2;
        end
        K_PROBE: begin
          act = ACT_LOOP;
          if (resp <= 8'd1) begin
            det_type_nxt = TYPE_SDV1; a_sel = SEL_PRE_ZERO; a_ret = K_V1;
          end else begin
            det_type_nxt = TYPE_MMC; a_sel = SEL_CMD1; a_ret = K_MMC;
          end
        end
        K_V1: begin
          if (resp == 8'd0) begin
            act = ACT_CMD; a_sel = SEL_CMD16; a_ret = K_CMD16;
          end else begin
            act = ACT_RETRY; a_sel = SEL_PRE_ZERO; a_ret = K_V1;
          end
        end
        K_MMC: begin
          if (resp == 8'd0) begin
            act = ACT_CMD; a_sel = SEL_CMD16; a_ret = K_CMD16;
          end else begin
            act = ACT_RETRY; a_sel = SEL_CMD1; a_ret = K_MMC;
          end
        end
        K_CMD16: begin
          act    = ACT_FINISH;
          a_type = (resp == 8'd0) ? det_type_r : TYPE_NONE;
        end
        default: act = ACT_FINISH;
      endcase
    end

    // retry loop bookkeeping: a zero count fails the run
    if (act == ACT_LOOP || act == ACT_RETRY) begin
      rv            = (act == ACT_LOOP) ? init_retry_r : retry_cnt_r - 16'd1;
      retry_cnt_nxt = rv;
      if (rv == 16'd0) begin
        act    = ACT_FINISH;
        a_type = TYPE_NONE;
      end else begin
        act = ACT_CMD;
      end
    end

    unique case (act)
      ACT_CMD: begin
        cmd_sel_nxt   = a_sel;
        ret_phase_nxt = a_ret;
        phase_nxt     = P_DISCARD;
        res_nxt       = mk_emit(BYTE_IDLE, 1'b0, 1'b1);
      end
      ACT_TRAILER: begin
        ret_phase_nxt = a_ret;
        trl_idx_nxt   = 2'd0;
        trl_ok_nxt    = 1'b0;
        phase_nxt     = P_TRAILER;
        res_nxt       = mk_emit(BYTE_IDLE, 1'b0, 1'b0);
      end
      ACT_FINISH: begin
        det_type_nxt = a_type;
        phase_nxt    = P_RELEASE;
        res_nxt      = mk_emit(BYTE_IDLE, 1'b1, 1'b0);
      end
      default: ;
    endcase
  end

  // ---------------- handshake and state registers
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_IDLE;
      ret_phase_r <= P_IDLE;
      retry_cnt_r <= 16'd0;
      wait_cnt_r  <= 16'd0;
      frame_idx_r <= 3'd0;
      cmd_sel_r   <= SEL_CMD0;
      last_resp_r <= 8'd0;
      trl_idx_r   <= 2'd0;
      trl_ok_r    <= 1'b0;
      det_type_r  <= TYPE_NONE;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      ret_phase_r <= ret_phase_nxt;
      retry_cnt_r <= retry_cnt_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      frame_idx_r <= frame_idx_nxt;
      cmd_sel_r   <= cmd_sel_nxt;
      last_resp_r <= last_resp_nxt;
      trl_idx_r   <= trl_idx_nxt;
      trl_ok_r    <= trl_ok_nxt;
      det_type_r  <= det_type_nxt;
    end
  end

  // result register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) out_data_r <= skid_data_r;
    end else if (in_acc) begin
      if (!out_valid_r || out_take) out_data_r <= res_nxt;
      else skid_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while result register empty");

  a_start_to_dummy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.start_req |=> phase_r == P_DUMMY)
    else $error("start beat did not enter dummy phase");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_nxt.done_res |=> phase_r == P_IDLE)
    else $error("done beat left sequencer busy");

  a_done_no_xchg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.exchange && out_data_r.done_res))
    else $error("done beat also requests an exchange");

  a_pulse_selected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.cs_pulse |-> out_data_r.exchange && !out_data_r.cs_level)
    else $error("cs pulse without a selected exchange");

endmodule

// ===== bench/sd_card_spi_init_sequencer_top_tb.sv =====
// Self-checking bench for the SD card SPI init sequencer, driven by an emulated card.
module sd_card_spi_init_sequencer_top_tb;
  import sdi_pkg::*;

  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_ILLEGAL = 8'h05;

  typedef enum logic [2:0] {
    CARD_SDHC, CARD_SDSC2, CARD_SDV1, CARD_MMC, CARD_BAD_R7, CARD_MUTE, CARD_STUCK
  } card_kind_t;

  // Tracks the sequencer state and holds the results still owed by the block.
  class spi_init_tracker;
    logic [15:0] retry_lim = INIT_RETRY_RST;
    logic [15:0] ready_lim = READY_WAIT_RST;
    logic [7:0]  dummy_cnt = DUMMY_CNT_RST;
    logic [3:0]  poll_lim  = RESP_POLL_RST;
    phase_t      phase = P_IDLE;
    phase_t      return_phase = P_IDLE;
    cmd_sel_t    command_select = SEL_CMD0;
    logic [15:0] retry_count = '0;
    logic [15:0] wait_count = '0;
    logic [2:0]  frame_index = '0;
    logic [7:0]  last_response = '0;
    logic [1:0]  trailer_index = '0;
    logic        trailer_ok = 1'b0;
    logic [3:0]  detected_type = TYPE_NONE;
    sdi_out_t    step_out;
    sdi_out_t    awaited[$];
    int          bad = 0;

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_INIT_RETRY: retry_lim = v[15:0];
        REG_READY_WAIT: ready_lim = v[15:0];
        REG_DUMMY_CNT:  dummy_cnt = v[7:0];
        REG_RESP_POLL:  poll_lim  = v[3:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] cmd_byte(cmd_sel_t s, int idx);
      logic [47:0] f;
      case (s)
        SEL_CMD8:        f = 48'h48_00_00_01_AA_87;
        SEL_PRE_HCS:     f = 48'h77_00_00_00_00_01;
        SEL_ACMD41_HCS:  f = 48'h69_40_00_00_00_01;
        SEL_PRE_ZERO:    f = 48'h77_00_00_00_00_01;
        SEL_ACMD41_ZERO: f = 48'h69_00_00_00_00_01;
        SEL_CMD1:        f = 48'h41_00_00_00_00_01;
        SEL_CMD16:       f = 48'h50_00_00_02_00_01;
        SEL_CMD58:       f = 48'h7A_00_00_00_00_01;
        default:         f = 48'h40_00_00_00_00_95;
      endcase
      return f[8*(5-idx) +: 8];
    endfunction

    function void xfer(logic [7:0] tx, logic cs, logic pulse);
      step_out = RES_IDLE;
      step_out.exchange = 1'b1;
      step_out.tx_byte  = tx;
      step_out.cs_level = cs;
      step_out.cs_pulse = pulse;
    endfunction

    function void begin_cmd(cmd_sel_t s, phase_t k);
      command_select = s;
      return_phase = k;
      phase = P_DISCARD;
      xfer(BYTE_IDLE, 1'b0, 1'b1);
    endfunction

    function void begin_trailer(phase_t k);
      return_phase = k;
      trailer_index = '0;
      trailer_ok = 1'b0;
      phase = P_TRAILER;
      xfer(BYTE_IDLE, 1'b0, 1'b0);
    endfunction

    function void wrap_up(logic [3:0] ty);
      detected_type = ty;
      phase = P_RELEASE;
      xfer(BYTE_IDLE, 1'b1, 1'b0);
    endfunction

    function void begin_loop(cmd_sel_t s, phase_t k);
      retry_count = retry_lim;
      if (retry_count == 0) wrap_up(TYPE_NONE);
      else begin_cmd(s, k);
    endfunction

    function void retry_or_fail(cmd_sel_t s, phase_t k);
      retry_count = retry_count - 16'd1;
      if (retry_count == 0) wrap_up(TYPE_NONE);
      else begin_cmd(s, k);
    endfunction

    function void route(logic [7:0] res);
      case (return_phase)
        K_CMD0:  if (res == R1_IDLE) begin_cmd(SEL_CMD8, K_CMD8); else wrap_up(TYPE_NONE);
        K_CMD8:  if (res == R1_IDLE) begin_trailer(K_R7); else begin_cmd(SEL_PRE_ZERO, K_PROBE);
        K_R7:    if (trailer_ok) begin_loop(SEL_PRE_HCS, K_HCS); else wrap_up(TYPE_NONE);
        K_HCS: begin
          if (res == R1_READY) begin_cmd(SEL_CMD58, K_CMD58);
          else retry_or_fail(SEL_PRE_HCS, K_HCS);
        end
        K_CMD58: if (res == R1_READY) begin_trailer(K_OCR); else wrap_up(TYPE_NONE);
        K_OCR:   wrap_up(trailer_ok ? TYPE_SDV2B : TYPE_SDV2);
        K_PROBE: begin
          // CMD55/ACMD41 accepted means SDv1, rejected means MMC
          if (res <= R1_IDLE) begin
            detected_type = TYPE_SDV1;
            begin_loop(SEL_PRE_ZERO, K_V1);
          end else begin
            detected_type = TYPE_MMC;
            begin_loop(SEL_CMD1, K_MMC);
          end
        end
        K_V1: begin
          if (res == R1_READY) begin_cmd(SEL_CMD16, K_CMD16);
          else retry_or_fail(SEL_PRE_ZERO, K_V1);
        end
        K_MMC: begin
          if (res == R1_READY) begin_cmd(SEL_CMD16, K_CMD16);
          else retry_or_fail(SEL_CMD1, K_MMC);
        end
        K_CMD16: wrap_up(res == R1_READY ? detected_type : TYPE_NONE);
        default: wrap_up(TYPE_NONE);
      endcase
    endfunction

    function void take_r1(logic [7:0] res);
      last_response = res;
      // a good CMD55 moves on to the app command itself
      if ((command_select == SEL_PRE_HCS || command_select == SEL_PRE_ZERO) && res <= R1_IDLE)
        begin_cmd(cmd_sel_t'(command_select + 4'd1), return_phase);
      else
        route(res);
    endfunction

    function sdi_out_t predict_step(sdi_in_t it);
      step_out = RES_IDLE;
      if (it.start_req) begin
        detected_type = TYPE_NONE;
        wait_count = (dummy_cnt != 0) ? {8'd0, dummy_cnt} : 16'd1;
        phase = P_DUMMY;
        xfer(BYTE_IDLE, 1'b1, 1'b0);
      end else begin
        case (phase)
          P_DUMMY: begin
            wait_count = wait_count - 16'd1;
            if (wait_count != 0) xfer(BYTE_IDLE, 1'b1, 1'b0);
            else begin_cmd(SEL_CMD0, K_CMD0);
          end
          P_DISCARD: begin
            wait_count = (ready_lim != 0) ? ready_lim : 16'd1;
            phase = P_READY;
            xfer(BYTE_IDLE, 1'b0, 1'b0);
          end
          P_READY: begin
            if (it.rx_byte == BYTE_IDLE) begin
              frame_index = '0;
              phase = P_FRAME;
              xfer(cmd_byte(command_select, 0), 1'b0, 1'b0);
            end else begin
              wait_count = wait_count - 16'd1;
              if (wait_count == 0) take_r1(BYTE_IDLE);
              else xfer(BYTE_IDLE, 1'b0, 1'b0);
            end
          end
          P_FRAME: begin
            frame_index = frame_index + 3'd1;
            if (frame_index < FRAME_LEN) begin
              xfer(cmd_byte(command_select, int'(frame_index)), 1'b0, 1'b0);
            end else begin
              wait_count = (poll_lim != 0) ? {12'd0, poll_lim} : 16'd1;
              phase = P_RESP;
              xfer(BYTE_IDLE, 1'b0, 1'b0);
            end
          end
          P_RESP: begin
            wait_count = wait_count - 16'd1;
            if (it.rx_byte[7] && wait_count != 0) xfer(BYTE_IDLE, 1'b0, 1'b0);
            else take_r1(it.rx_byte);
          end
          P_TRAILER: begin
            if (return_phase == K_OCR) begin
              if (trailer_index == 2'd0) trailer_ok = it.rx_byte[6];
            end else if (trailer_index == 2'd2) begin
              trailer_ok = (it.rx_byte == R7_VOLT);
            end else if (trailer_index == 2'd3) begin
              trailer_ok = trailer_ok && (it.rx_byte == R7_CHECK);
            end
            if (trailer_index == 2'd3) begin
              route(last_response);
            end else begin
              trailer_index = trailer_index + 2'd1;
              xfer(BYTE_IDLE, 1'b0, 1'b0);
            end
          end
          P_RELEASE: begin
            phase = P_IDLE;
            step_out.done_res  = 1'b1;
            step_out.card_type = detected_type;
          end
          default: phase = P_IDLE;
        endcase
      end
      return step_out;
    endfunction

    function void note_beat(sdi_in_t it);
      awaited.push_back(predict_step(it));
    endfunction

    function void diff(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        bad++;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_beat(sdi_out_t got);
      sdi_out_t want;
      if (awaited.size() == 0) begin
        bad++;
        $display("%0t: result with none expected, expected nothing, got %p", $time, got);
        return;
      end
      want = awaited.pop_front();
      diff("exchange", 8'(want.exchange), 8'(got.exchange));
      diff("tx_byte", want.tx_byte, got.tx_byte);
      diff("cs_level", 8'(want.cs_level), 8'(got.cs_level));
      diff("cs_pulse", 8'(want.cs_pulse), 8'(got.cs_pulse));
      diff("done_res", 8'(want.done_res), 8'(got.done_res));
      diff("card_type", 8'(want.card_type), 8'(got.card_type));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  sdi_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  sdi_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spi_init_tracker sb = new();
  card_kind_t      card = CARD_SDHC;
  logic            calm = 1'b0;

  sd_card_spi_init_sequencer_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_beat(out_data);
  end

  function automatic logic [7:0] r1_reply();
    if ($urandom_range(99) < 4) return 8'($urandom_range(127));
    case (sb.command_select)
      SEL_CMD0: return R1_IDLE;
      SEL_CMD8: return (card == CARD_SDV1 || card == CARD_MMC) ? R1_ILLEGAL : R1_IDLE;
      SEL_PRE_HCS, SEL_PRE_ZERO: return (card == CARD_MMC) ? R1_ILLEGAL : R1_IDLE;
      SEL_CMD16, SEL_CMD58: return R1_READY;
      // init loops: leave idle after a few tries unless the card never does
      default: return (card != CARD_STUCK && $urandom_range(99) < 35) ? R1_READY : R1_IDLE;
    endcase
  endfunction

  // byte the emulated card clocks back for the exchange in flight
  function automatic logic [7:0] card_reply();
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    case (sb.phase)
      P_READY: return ($urandom_range(99) < (sb.ready_lim > 2 ? 15 : 4)) ? junk : BYTE_IDLE;
      P_RESP: begin
        if (card == CARD_MUTE || $urandom_range(99) < (sb.poll_lim > 2 ? 25 : 5))
          return junk | 8'h80;
        return r1_reply();
      end
      P_TRAILER: begin
        if (sb.return_phase == K_OCR)
          return (sb.trailer_index == 2'd0) ? {1'b1, card == CARD_SDHC, junk[5:0]} : junk;
        if (sb.trailer_index == 2'd2) return (card == CARD_BAD_R7 && junk[7]) ? junk : R7_VOLT;
        if (sb.trailer_index == 2'd3) return (card == CARD_BAD_R7 && !junk[7]) ? junk : R7_CHECK;
        return junk;
      end
      default: return junk;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic push_item(input logic go, input logic [7:0] rx);
    sdi_in_t it;
    it.start_req = go;
    it.rx_byte   = rx;
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_beat(it);
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // back-to-back APB writes of all four registers
  task automatic write_regs(input logic [15:0] r, input logic [15:0] rd, input logic [7:0] d,
                            input logic [3:0] p);
    logic [31:0] vals[4];
    logic [1:0]  idx[4];
    vals = '{{16'd0, r}, {16'd0, rd}, {24'd0, d}, {28'd0, p}};
    idx  = '{REG_INIT_RETRY, REG_READY_WAIT, REG_DUMMY_CNT, REG_RESP_POLL};
    for (int i = 0; i < 4; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx[i], 2'b00};
      pwdata  <= vals[i];
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.set_reg(idx[i], vals[i]);
      @(negedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int         ph;
    int         n;
    int         n_items;
    int         noise_pct;
    logic       go;
    logic [7:0] rx;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle beats, start, dummy beats, restart while busy
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, 8'h5A);
    push_item(1'b1, 8'h00);
    push_item(1'b0, 8'hA5);
    push_item(1'b0, 8'hFF);
    push_item(1'b1, 8'hFF);
    push_item(1'b0, 8'h00);

    for (ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        in_valid <= 1'b0;
        drain();
        case (ph)
          1: write_regs(16'd1, 16'd1, 8'd1, 4'd1);
          2: write_regs(16'd0, 16'd0, 8'd0, 4'd0);
          3: write_regs(16'hFFFF, 16'hFFFF, 8'hFF, 4'hF);
          4: write_regs(16'd3, 16'd2, 8'd4, 4'd2);
          5: write_regs(16'($urandom_range(40, 1)), 16'($urandom_range(6, 1)),
                        8'($urandom_range(8, 1)), 4'($urandom_range(15, 1)));
          default: write_regs(16'd8, 16'd3, 8'd2, 4'hF);
        endcase
      end
      calm = (ph == 6);
      // full-size dummy run needs a long quiet phase to get past the dummy bytes
      n_items   = (ph == 3) ? 330 : 85;
      noise_pct = (ph == 3) ? 0 : 3;
      for (n = 0; n < n_items; n++) begin
        rx = 8'($urandom_range(255));
        go = 1'b0;
        if ($urandom_range(99) < noise_pct) begin
          go = 1'($urandom_range(1));
        end else if (sb.phase == P_IDLE) begin
          go = ($urandom_range(9) != 0);
          if (go) card = card_kind_t'($urandom_range(sb.retry_lim <= 40 ? 6 : 5));
        end else begin
          rx = card_reply();
        end
        push_item(go, rx);
      end
    end

    in_valid <= 1'b0;
    drain();
    if (sb.bad == 0 && sb.awaited.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sdi_pkg.sv
rtl/core/sd_card_spi_init_sequencer_top.sv
bench/sd_card_spi_init_sequencer_top_tb.sv
